// ===== rtl/core/retc_pkg.sv =====
// shared types and constants for the radiation error temperature correction block
// no dependencies; imported by radiation_error_temp_correction
package retc_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPP_WIND  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SNOW_DEPTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SNOW_ALB   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOIL_ALB   = 3'd4;

    // mode codes
    localparam logic [1:0] MODE_HUWALD   = 2'd0;
    localparam logic [1:0] MODE_NAKAMURA = 2'd1;
    localparam logic [1:0] MODE_SUPPRESS = 2'd2;

    // register reset values
    localparam logic [1:0]  RST_MODE       = MODE_HUWALD;
    localparam logic [13:0] RST_SUPP_WIND  = 14'd0;
    localparam logic [13:0] RST_SNOW_DEPTH = 14'd100;
    localparam logic [15:0] RST_SNOW_ALB   = 16'd55706;
    localparam logic [15:0] RST_SOIL_ALB   = 16'd15073;

    // arithmetic constants
    localparam logic [13:0] WIND_FLOOR = 14'd10;
    localparam logic [9:0]  DEN_K      = 10'd753;
    // 2*23337500 = 8*5834375, 60062500000*256 = 8192*1876953125
    localparam logic [30:0] NAK_MUL    = 31'd5834375;
    localparam logic [30:0] HUW_MUL    = 31'd1876953125;
    localparam logic [23:0] NAK_CMP    = 24'd6250000;
    localparam logic [23:0] HUW_CMP    = 24'd12500000;
    localparam logic [17:0] NAK_OFS    = 18'd13;

    // pipeline depths
    localparam int FD_STEPS = 32;
    localparam int MD_STEPS = 40;
    localparam int SQ_STEPS = 20;
    localparam int NSTAGE   = 2 + (FD_STEPS + 1) + 2 + (MD_STEPS + 1) + (SQ_STEPS + 1);

    typedef struct packed {
        logic [15:0] base_temp;
        logic        base_valid;
        logic        corr;
        logic        nak;
    } ctl_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [15:0] ta;
        logic [14:0] isw;
        logic        isw_ok;
        logic [14:0] rsw;
        logic        rsw_ok;
        logic [13:0] v;
        logic [15:0] alb;
        logic        nak_fill;
        logic        huw_fill;
    } s1_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [14:0] isw;
        logic        isw_ok;
        logic [14:0] rsw;
        logic        rsw_ok;
        logic        nak_fill;
        logic        huw_fill;
        logic [29:0] tv;
        logic [30:0] hprod;
        logic [15:0] alb;
        logic [31:0] numf;
    } s2_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [39:0] den;
        logic [14:0] isw;
        logic [14:0] rsw;
        logic        sw_ok;
        logic        nak_fill;
        logic [15:0] alb;
        logic [15:0] rem;
        logic [31:0] nq;
    } fd_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [39:0] den;
        logic        sw_ok;
        logic [53:0] p;
        logic [53:0] pc;
    } m1_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [58:0] n;
        logic [40:0] d;
    } m2_t;

    typedef struct packed {
        ctl_t        ctl;
        logic        ovf;
        logic [40:0] d;
        logic [40:0] rem;
        logic [39:0] nq;
    } md_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [17:0] re_n;
        logic [39:0] x;
        logic [39:0] res;
    } sq_t;

endpackage

// ===== rtl/core/radiation_error_temp_correction.sv =====
// radiation error temperature correction, top level and full pipeline
// depends on retc_pkg
//
// throughput: one beat per cycle; the pipeline stalls only when the two-entry output
// buffer is full, so one finished beat can wait while the pipe still moves on
// reset: rst_n asynchronous active low, clears all valid bits and loads the config
// registers with their default values
module radiation_error_temp_correction
(
    input  logic                              clk,
    input  logic                              rst_n,
    // air_temp[15:0], air_temp_valid[16], incoming_sw[31:17], incoming_sw_valid[32],
    // reflected_sw[47:33], reflected_sw_valid[48], wind_speed[62:49],
    // wind_speed_valid[63], snow_height[77:64], snow_height_valid[78], zero[79]
    input  logic [retc_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // corrected_temp[15:0], corrected_temp_valid[16], correction_applied[17], zero[23:18]
    output logic [retc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [retc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [retc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import retc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [1:0]  mode_reg;
    logic [13:0] supp_wind_reg;
    logic [13:0] snow_depth_reg;
    logic [15:0] snow_alb_reg;
    logic [15:0] soil_alb_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= RST_MODE;
            supp_wind_reg  <= RST_SUPP_WIND;
            snow_depth_reg <= RST_SNOW_DEPTH;
            snow_alb_reg   <= RST_SNOW_ALB;
            soil_alb_reg   <= RST_SOIL_ALB;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[1:0];
                REG_SUPP_WIND:  supp_wind_reg  <= cfg_data[13:0];
                REG_SNOW_DEPTH: snow_depth_reg <= cfg_data[13:0];
                REG_SNOW_ALB:   snow_alb_reg   <= cfg_data;
                REG_SOIL_ALB:   soil_alb_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // whole pipe advances together; it halts only when the skid entry is occupied
    logic              en;
    logic              skid_valid_reg;
    logic [NSTAGE-1:0] vld_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGE-2:0], s_tvalid};
    end

    // ---------------- stage 1: unpack, decide pass-through cases ----------------
    logic [15:0] in_ta;
    logic        in_ta_ok;
    logic [14:0] in_isw;
    logic        in_isw_ok;
    logic [14:0] in_rsw;
    logic        in_rsw_ok;
    logic [13:0] in_vw;
    logic        in_vw_ok;
    logic [13:0] in_hs;
    logic        in_hs_ok;
    logic        suppress;
    s1_t         s1_next;
    s1_t         s1_reg;

    assign in_ta     = s_tdata[15:0];
    assign in_ta_ok  = s_tdata[16];
    assign in_isw    = s_tdata[31:17];
    assign in_isw_ok = s_tdata[32];
    assign in_rsw    = s_tdata[47:33];
    assign in_rsw_ok = s_tdata[48];
    assign in_vw     = s_tdata[62:49];
    assign in_vw_ok  = s_tdata[63];
    assign in_hs     = s_tdata[77:64];
    assign in_hs_ok  = s_tdata[78];

    // mode three acts like suppress mode
    assign suppress = mode_reg[1] && in_vw_ok && (in_vw < supp_wind_reg);

    always_comb
    begin
        s1_next                = '0;
        s1_next.ctl.nak        = (mode_reg == MODE_NAKAMURA);
        s1_next.ctl.base_valid = in_ta_ok && !suppress;
        s1_next.ctl.base_temp  = (in_ta_ok && !suppress) ? in_ta : 16'd0;
        // wind must be present for any correction
        s1_next.ctl.corr       = in_ta_ok && !mode_reg[1] && (in_ta != 16'd0) && in_vw_ok;
        s1_next.ta             = in_ta;
        s1_next.isw            = in_isw;
        s1_next.isw_ok         = in_isw_ok;
        s1_next.rsw            = in_rsw;
        s1_next.rsw_ok         = in_rsw_ok;
        s1_next.v              = (in_vw < WIND_FLOOR) ? WIND_FLOOR : in_vw;
        s1_next.alb            = (in_hs > snow_depth_reg) ? snow_alb_reg : soil_alb_reg;
        s1_next.nak_fill       = in_hs_ok && !in_isw_ok && in_rsw_ok && (s1_next.alb != 16'd0);
        s1_next.huw_fill       = in_hs_ok && !in_rsw_ok && in_isw_ok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s1_reg <= s1_next;
    end

    // ---------------- stage 2: temperature times wind, fill products ----------------
    s2_t s2_next;
    s2_t s2_reg;

    always_comb
    begin
        s2_next          = '0;
        s2_next.ctl      = s1_reg.ctl;
        s2_next.isw      = s1_reg.isw;
        s2_next.isw_ok   = s1_reg.isw_ok;
        s2_next.rsw      = s1_reg.rsw;
        s2_next.rsw_ok   = s1_reg.rsw_ok;
        s2_next.nak_fill = s1_reg.nak_fill;
        s2_next.huw_fill = s1_reg.huw_fill;
        s2_next.tv       = {14'd0, s1_reg.ta} * {16'd0, s1_reg.v};
        s2_next.hprod    = {16'd0, s1_reg.isw} * {15'd0, s1_reg.alb};
        s2_next.alb      = s1_reg.alb;
        // rounded numerator for filling incoming shortwave from reflected
        s2_next.numf     = {1'b0, s1_reg.rsw, 16'd0} + {17'd0, s1_reg.alb[15:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_reg <= s2_next;
    end

    // ---------------- fill divider: numf / albedo, one quotient bit per stage ----------------
    fd_t         fd_next [FD_STEPS+1];
    fd_t         fd_reg  [FD_STEPS+1];
    logic [39:0] den_full;
    logic [31:0] hfill_sum;

    assign den_full  = {30'd0, DEN_K} * {10'd0, s2_reg.tv};
    assign hfill_sum = {1'b0, s2_reg.hprod} + 32'd32768;

    always_comb
    begin
        fd_next[0]          = '0;
        fd_next[0].ctl      = s2_reg.ctl;
        fd_next[0].den      = den_full;
        fd_next[0].isw      = s2_reg.isw;
        // huwald fill of missing reflected shortwave
        fd_next[0].rsw      = s2_reg.huw_fill ? hfill_sum[30:16] : s2_reg.rsw;
        fd_next[0].sw_ok    = s2_reg.ctl.nak ? s2_reg.isw_ok
                                             : (s2_reg.rsw_ok || s2_reg.huw_fill);
        fd_next[0].nak_fill = s2_reg.nak_fill;
        fd_next[0].alb      = s2_reg.alb;
        fd_next[0].rem      = 16'd0;
        fd_next[0].nq       = s2_reg.numf;
    end

    genvar gk;
    generate
        for (gk = 1; gk <= FD_STEPS; gk++)
        begin : g_fd
            logic [16:0] t;
            logic        ge;

            assign t  = {fd_reg[gk-1].rem, fd_reg[gk-1].nq[31]};
            assign ge = (t >= {1'b0, fd_reg[gk-1].alb});

            always_comb
            begin
                fd_next[gk]     = fd_reg[gk-1];
                fd_next[gk].rem = ge ? 16'(t - {1'b0, fd_reg[gk-1].alb}) : t[15:0];
                fd_next[gk].nq  = {fd_reg[gk-1].nq[30:0], ge};
            end
        end

        for (gk = 0; gk <= FD_STEPS; gk++)
        begin : g_fd_reg
            always_ff @(posedge clk)
            begin
                if (en)
                    fd_reg[gk] <= fd_next[gk];
            end
        end
    endgenerate

    // ---------------- m1: scheme products ----------------
    m1_t         m1_next;
    m1_t         m1_reg;
    logic [30:0] mul_a;
    logic [30:0] mul_c;
    logic [23:0] cmp_c;
    logic [61:0] mul_p;
    logic [54:0] cmp_p;

    always_comb
    begin
        if (fd_reg[FD_STEPS].ctl.nak)
        begin
            mul_a = fd_reg[FD_STEPS].nak_fill ? fd_reg[FD_STEPS].nq[30:0]
                                              : {16'd0, fd_reg[FD_STEPS].isw};
            mul_c = NAK_MUL;
            cmp_c = NAK_CMP;
        end
        else
        begin
            mul_a = {16'd0, fd_reg[FD_STEPS].rsw};
            mul_c = HUW_MUL;
            cmp_c = HUW_CMP;
        end
    end

    assign mul_p = {31'd0, mul_a} * {31'd0, mul_c};
    assign cmp_p = {24'd0, mul_a} * {31'd0, cmp_c};

    always_comb
    begin
        m1_next       = '0;
        m1_next.ctl   = fd_reg[FD_STEPS].ctl;
        m1_next.den   = fd_reg[FD_STEPS].den;
        m1_next.sw_ok = fd_reg[FD_STEPS].sw_ok || fd_reg[FD_STEPS].nak_fill;
        m1_next.p     = mul_p[53:0];
        m1_next.pc    = cmp_p[53:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m1_reg <= m1_next;
    end

    // ---------------- m2: threshold test, dividend and divisor ----------------
    m2_t m2_next;
    m2_t m2_reg;

    always_comb
    begin
        m2_next          = '0;
        m2_next.ctl      = m1_reg.ctl;
        // small X skips the correction
        m2_next.ctl.corr = m1_reg.ctl.corr && m1_reg.sw_ok
                           && (m1_reg.pc >= {14'd0, m1_reg.den});
        if (m1_reg.ctl.nak)
        begin
            // (2*I*23337500 + den) / (2*den) rounds half up
            m2_next.n = {2'd0, m1_reg.p, 3'd0} + {19'd0, m1_reg.den};
            m2_next.d = {m1_reg.den, 1'b0};
        end
        else
        begin
            m2_next.n = {m1_reg.p[45:0], 13'd0};
            m2_next.d = {1'b0, m1_reg.den};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m2_reg <= m2_next;
    end

    // ---------------- main divider: 40 quotient bits, saturating ----------------
    md_t md_next [MD_STEPS+1];
    md_t md_reg  [MD_STEPS+1];

    always_comb
    begin
        md_next[0]     = '0;
        md_next[0].ctl = m2_reg.ctl;
        // quotient of 2^40 or more only needs to saturate
        md_next[0].ovf = ({22'd0, m2_reg.n[58:40]} >= m2_reg.d);
        md_next[0].d   = m2_reg.d;
        md_next[0].rem = {22'd0, m2_reg.n[58:40]};
        md_next[0].nq  = m2_reg.n[39:0];
    end

    generate
        for (gk = 1; gk <= MD_STEPS; gk++)
        begin : g_md
            logic [41:0] t;
            logic        ge;

            assign t  = {md_reg[gk-1].rem, md_reg[gk-1].nq[39]};
            assign ge = (t >= {1'b0, md_reg[gk-1].d});

            always_comb
            begin
                md_next[gk]     = md_reg[gk-1];
                md_next[gk].rem = ge ? 41'(t - {1'b0, md_reg[gk-1].d}) : t[40:0];
                md_next[gk].nq  = {md_reg[gk-1].nq[38:0], ge};
            end
        end

        for (gk = 0; gk <= MD_STEPS; gk++)
        begin : g_md_reg
            always_ff @(posedge clk)
            begin
                if (en)
                    md_reg[gk] <= md_next[gk];
            end
        end
    endgenerate

    // ---------------- square root: one result bit per stage ----------------
    sq_t         sq_next [SQ_STEPS+1];
    sq_t         sq_reg  [SQ_STEPS+1];
    logic [39:0] q_sat;
    logic [16:0] q_nak;

    assign q_sat = md_reg[MD_STEPS].ovf ? '1 : md_reg[MD_STEPS].nq;
    assign q_nak = (|q_sat[39:17]) ? '1 : q_sat[16:0];

    always_comb
    begin
        sq_next[0]      = '0;
        sq_next[0].ctl  = md_reg[MD_STEPS].ctl;
        sq_next[0].re_n = {1'b0, q_nak} + NAK_OFS;
        sq_next[0].x    = q_sat;
        sq_next[0].res  = 40'd0;
    end

    generate
        for (gk = 1; gk <= SQ_STEPS; gk++)
        begin : g_sq
            localparam logic [39:0] BIT = 40'd1 << (38 - 2 * (gk - 1));
            logic [39:0] rb;
            logic        ge;

            assign rb = sq_reg[gk-1].res + BIT;
            assign ge = (sq_reg[gk-1].x >= rb);

            always_comb
            begin
                sq_next[gk]     = sq_reg[gk-1];
                sq_next[gk].x   = ge ? (sq_reg[gk-1].x - rb) : sq_reg[gk-1].x;
                sq_next[gk].res = ge ? ((sq_reg[gk-1].res >> 1) + BIT)
                                     : (sq_reg[gk-1].res >> 1);
            end
        end

        for (gk = 0; gk <= SQ_STEPS; gk++)
        begin : g_sq_reg
            always_ff @(posedge clk)
            begin
                if (en)
                    sq_reg[gk] <= sq_next[gk];
            end
        end
    endgenerate

    // ---------------- final subtract ----------------
    sq_t         last;
    logic [21:0] re_h_sum;
    logic [17:0] re;
    logic [15:0] fin_temp;
    logic [17:0] fin_data;

    assign last     = sq_reg[SQ_STEPS];
    // sqrt has four fraction bits, round half up
    assign re_h_sum = {1'b0, last.res[20:0]} + 22'd8;
    assign re       = last.ctl.nak ? last.re_n : {1'b0, re_h_sum[20:4]};

    always_comb
    begin
        if (!last.ctl.corr)
            fin_temp = last.ctl.base_temp;
        else if (re < {2'd0, last.ctl.base_temp})
            fin_temp = 16'({2'd0, last.ctl.base_temp} - re);
        else
            fin_temp = 16'd0;
    end

    assign fin_data = {last.ctl.corr, last.ctl.base_valid, fin_temp};

    // ---------------- output register plus skid entry ----------------
    logic        out_valid_reg;
    logic [17:0] out_data_reg;
    logic [17:0] skid_data_reg;
    logic        pop;
    logic        push;

    assign pop  = out_valid_reg && m_tready;
    assign push = en && vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= fin_data;
            else
                out_data_reg <= fin_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

    // ---------------- assertions ----------------
    // skid entry is only filled behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output beat");

    // a correction is only reported on a valid temperature
    a_applied_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[17]) |-> m_tdata[16])
        else $error("correction applied on invalid temperature");

    // an unaccepted output beat with full skid keeps the pipe frozen
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(vld_reg)))
        else $error("pipeline moved while output buffer full");

endmodule

// ===== verif/tb_top.sv =====
// self-checking bench for radiation_error_temp_correction: weather records in, corrected temps out
// depends on retc_pkg and the block rtl; a bit-exact predictor checks every output beat in order
module tb_top;

    import retc_pkg::*;

    // watchdog limit in cycles without any accepted beat
    localparam int WDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RAND_PER_SET = 186;
    // spare mode code, behaves as suppress
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // one input record, unpacked
    typedef struct {
        logic [15:0] ta;
        logic        ta_ok;
        logic [14:0] isw;
        logic        isw_ok;
        logic [14:0] rsw;
        logic        rsw_ok;
        logic [13:0] vw;
        logic        vw_ok;
        logic [13:0] hs;
        logic        hs_ok;
    } wx_rec_t;

    // scoreboard: keeps its own copy of the registers and the expected output beats
    class retc_scoreboard;
        logic [1:0]  mode;
        logic [13:0] supp_wind;
        logic [13:0] snow_depth;
        logic [15:0] snow_alb;
        logic [15:0] soil_alb;
        logic [17:0] pending_temps[$];
        int          n_mismatch;
        int          n_checked;

        function new();
            mode       = RST_MODE;
            supp_wind  = RST_SUPP_WIND;
            snow_depth = RST_SNOW_DEPTH;
            snow_alb   = RST_SNOW_ALB;
            soil_alb   = RST_SOIL_ALB;
            n_mismatch = 0;
            n_checked  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MODE:       mode       = val[1:0];
                REG_SUPP_WIND:  supp_wind  = val[13:0];
                REG_SNOW_DEPTH: snow_depth = val[13:0];
                REG_SNOW_ALB:   snow_alb   = val[15:0];
                REG_SOIL_ALB:   soil_alb   = val[15:0];
                default: ;
            endcase
        endfunction

        // bitwise integer square root, 64-bit
        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // corrected_temp[15:0], valid[16], applied[17]
        function logic [17:0] correct_temp(logic [IN_TDATA_W-1:0] d);
            longint unsigned ta, isw, rsw, vw, hs, alb, v, den, re, sq;
            bit ta_ok, isw_ok, rsw_ok, vw_ok, hs_ok, use_re;
            logic [15:0] temp;
            bit valid, applied;
            ta = d[15:0];   ta_ok  = d[16];
            isw = d[31:17]; isw_ok = d[32];
            rsw = d[47:33]; rsw_ok = d[48];
            vw = d[62:49];  vw_ok  = d[63];
            hs = d[77:64];  hs_ok  = d[78];
            temp = d[15:0];
            valid = ta_ok;
            applied = 0;
            if (!ta_ok)
                temp = 16'd0;
            else if (mode[1])
            begin
                // suppress mode, also the spare mode code
                if (vw_ok && vw < supp_wind)
                begin
                    temp = 16'd0;
                    valid = 0;
                end
            end
            else if (ta != 0)
            begin
                alb = (hs > snow_depth) ? snow_alb : soil_alb;
                v = (vw < WIND_FLOOR) ? WIND_FLOOR : vw;
                den = DEN_K * ta * v;
                re = 0;
                use_re = 0;
                if (mode == MODE_NAKAMURA)
                begin
                    if (hs_ok && !isw_ok && rsw_ok && alb != 0)
                    begin
                        isw = (rsw * 65536 + (alb >> 1)) / alb;
                        isw_ok = 1;
                    end
                    if (isw_ok && vw_ok && isw * 64'd6250000 >= den)
                    begin
                        re = 13 + (2 * isw * 64'd23337500 + den) / (2 * den);
                        use_re = 1;
                    end
                end
                else
                begin
                    if (hs_ok && !rsw_ok && isw_ok)
                    begin
                        rsw = (isw * alb + 32768) >> 16;
                        rsw_ok = 1;
                    end
                    if (rsw_ok && vw_ok && rsw * 64'd12500000 >= den)
                    begin
                        sq = (rsw * 64'd60062500000 * 256) / den;
                        re = (int_sqrt(sq) + 8) >> 4;
                        use_re = 1;
                    end
                end
                if (use_re)
                begin
                    temp = (re < ta) ? 16'(ta - re) : 16'd0;
                    applied = 1;
                end
            end
            return {applied, valid, temp};
        endfunction

        function void note_record(logic [IN_TDATA_W-1:0] d);
            pending_temps.push_back(correct_temp(d));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            logic [17:0] exp_beat;
            n_checked++;
            if (pending_temps.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected output beat %h", d);
                return;
            end
            exp_beat = pending_temps.pop_front();
            if (d[15:0] !== exp_beat[15:0] || d[16] !== exp_beat[16] || d[17] !== exp_beat[17])
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch beat %0d: temp %0d/%0d valid %b/%b applied %b/%b (exp/act)",
                             n_checked, exp_beat[15:0], d[15:0], exp_beat[16], d[16],
                             exp_beat[17], d[17]);
            end
        endfunction
    endclass

    retc_scoreboard sb;
    int  idle_cycles = 0;
    bit  no_gaps;      // phases with no idling on either side

    radiation_error_temp_correction u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // monitor: every accepted beat goes to the scoreboard, also feeds the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_record(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // output side back-pressure
    initial
    begin : sink_proc
        int n;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            m_tready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    // one config beat, waits for the handshake; valid stays high for a following beat
    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // one input beat; tvalid stays high across back-to-back beats
    task automatic send_record(wx_rec_t w);
        int gap;
        s_tdata  <= {1'b0, w.hs_ok, w.hs, w.vw_ok, w.vw, w.rsw_ok, w.rsw,
                     w.isw_ok, w.isw, w.ta_ok, w.ta};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every expected beat has arrived, then let the pipe drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_temps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic wx_rec_t mk_rec(int ta, bit ta_ok, int isw, bit isw_ok, int rsw,
                                       bit rsw_ok, int vw, bit vw_ok, int hs, bit hs_ok);
        wx_rec_t w;
        w.ta = 16'(ta); w.ta_ok = ta_ok; w.isw = 15'(isw); w.isw_ok = isw_ok;
        w.rsw = 15'(rsw); w.rsw_ok = rsw_ok; w.vw = 14'(vw); w.vw_ok = vw_ok;
        w.hs = 14'(hs); w.hs_ok = hs_ok;
        return w;
    endfunction

    // random record: mostly plausible weather, sometimes full field range
    function automatic wx_rec_t rand_rec();
        wx_rec_t w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            w.ta = 16'd0;
        else if (r < 15)
            w.ta = 16'($urandom_range(0, 65535));
        else if (r < 25)
            w.ta = 16'($urandom_range(1, 2000));
        else
            w.ta = 16'($urandom_range(22000, 32000));
        w.isw = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                            : 15'($urandom_range(0, 12000));
        w.rsw = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                            : 15'($urandom_range(0, 9000));
        r = $urandom_range(0, 9);
        w.vw = (r == 0) ? 14'($urandom_range(0, 16383)) : (r < 3) ? 14'($urandom_range(0, 15))
                                                                 : 14'($urandom_range(0, 1500));
        w.hs = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                           : 14'($urandom_range(0, 400));
        w.ta_ok  = ($urandom_range(0, 9) != 0);
        w.isw_ok = ($urandom_range(0, 4) != 0);
        w.rsw_ok = ($urandom_range(0, 4) != 0);
        w.vw_ok  = ($urandom_range(0, 7) != 0);
        w.hs_ok  = ($urandom_range(0, 5) != 0);
        return w;
    endfunction

    // register settings per phase: mode, suppress wind, snow depth, snow albedo, soil albedo
    typedef struct {
        logic [1:0]  mode;
        logic [13:0] supp;
        logic [13:0] depth;
        logic [15:0] snow;
        logic [15:0] soil;
    } cfg_set_t;

    cfg_set_t phases[9];

    initial
    begin : stim_proc
        wx_rec_t directed[$];
        int k;
        sb = new();
        no_gaps = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        phases[0] = '{MODE_HUWALD,   14'd0,     14'd100,   16'd55706, 16'd15073};
        phases[1] = '{MODE_NAKAMURA, 14'd0,     14'd100,   16'd55706, 16'd15073};
        phases[2] = '{MODE_SUPPRESS, 14'd500,   14'd100,   16'd55706, 16'd15073};
        phases[3] = '{MODE_SPARE,    14'd16383, 14'd0,     16'd65535, 16'd1};
        phases[4] = '{MODE_NAKAMURA, 14'd300,   14'd16383, 16'd0,     16'd0};
        phases[5] = '{MODE_HUWALD,   14'd10000, 14'd0,     16'd65535, 16'd65535};
        phases[6] = '{MODE_NAKAMURA, 14'd0,     14'd100,   16'd1,     16'd65535};
        phases[7] = '{MODE_SUPPRESS, 14'd0,     14'd2000,  16'd40000, 16'd20000};
        phases[8] = '{MODE_HUWALD,   14'd50,    14'd2000,  16'd1,     16'd1};

        // edge cases: missing / zero temperature, field extremes, fills, saturation
        directed.push_back(mk_rec(25000, 0, 8000, 1, 4000, 1, 200, 1, 50, 1));
        directed.push_back(mk_rec(0,     1, 8000, 1, 4000, 1, 200, 1, 50, 1));
        directed.push_back(mk_rec(65535, 1, 32767, 1, 32767, 1, 0, 1, 16383, 1));
        directed.push_back(mk_rec(1,     1, 32767, 1, 32767, 1, 0, 1, 0, 1));
        directed.push_back(mk_rec(100,   1, 20000, 1, 20000, 1, 5, 1, 0, 1));
        directed.push_back(mk_rec(27315, 1, 9000, 1, 2000, 1, 16383, 1, 0, 1));
        directed.push_back(mk_rec(27315, 1, 9000, 1, 0, 0, 150, 1, 500, 1));
        directed.push_back(mk_rec(27315, 1, 9000, 1, 0, 0, 150, 1, 50, 1));
        directed.push_back(mk_rec(27315, 1, 9000, 1, 0, 0, 150, 1, 500, 0));
        directed.push_back(mk_rec(27315, 1, 0, 0, 3000, 1, 150, 1, 500, 1));
        directed.push_back(mk_rec(27315, 1, 0, 0, 3000, 1, 150, 1, 50, 1));
        directed.push_back(mk_rec(27315, 1, 0, 0, 0, 0, 150, 1, 500, 1));
        directed.push_back(mk_rec(27315, 1, 9000, 1, 3000, 1, 150, 0, 50, 1));
        directed.push_back(mk_rec(27315, 1, 1, 1, 1, 1, 9, 1, 100, 1));
        directed.push_back(mk_rec(27315, 1, 0, 1, 0, 1, 10, 1, 101, 1));
        directed.push_back(mk_rec(30000, 1, 16000, 1, 14000, 1, 11, 1, 16000, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 9; p++)
        begin
            // phase 0 runs on reset values; later ones write every register while idle
            if (p > 0)
            begin
                wait_idle();
                write_cfg(REG_MODE,       {14'd0, phases[p].mode});
                write_cfg(REG_SUPP_WIND,  {2'd0, phases[p].supp});
                write_cfg(REG_SNOW_DEPTH, {2'd0, phases[p].depth});
                write_cfg(REG_SNOW_ALB,   phases[p].snow);
                write_cfg(REG_SOIL_ALB,   phases[p].soil);
                cfg_valid <= 1'b0;
            end
            no_gaps = (p == 3 || p == 6);
            if (p < 5)
                foreach (directed[i])
                    send_record(directed[i]);
            for (k = 0; k < RAND_PER_SET; k++)
                send_record(rand_rec());
        end

        // end of stimulus: drain and report
        s_tvalid <= 1'b0;
        no_gaps = 0;
        @(posedge clk);
        while (sb.pending_temps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.n_mismatch == 0 && sb.pending_temps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/retc_pkg.sv
rtl/core/radiation_error_temp_correction.sv
verif/tb_top.sv
